@@ rtl/abe_pkg.sv @@
`timescale 1ns / 1ps

package abe_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int OUT_BITS       = 32;
    localparam int CHAR_BITS      = 8;

    localparam logic [CHAR_BITS-1:0] CH_0     = 8'd48;
    localparam logic [CHAR_BITS-1:0] CH_9     = 8'd57;
    localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'd43;
    localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'd45;
    localparam logic [CHAR_BITS-1:0] CH_STAR  = 8'd42;
    localparam logic [CHAR_BITS-1:0] CH_SLASH = 8'd47;
    localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'd32;
    localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_BITS-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_BITS-1:0] CH_NL    = 8'd10;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_NOOP = 2'd1,
        STAT_DIV0 = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_LEAD,
        ST_A,
        ST_PREOP,
        ST_POSTOP,
        ST_B,
        ST_REST,
        ST_CALC
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic acc_a;
        logic acc_b;
        logic acc_fresh;
        logic take_op;
        logic alu_start;
        logic finish;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_digit;
        logic is_ws;
        logic is_nl;
        logic alu_done;
    } t_stat;

endpackage

@@ rtl/abe_ctrl.sv @@
`timescale 1ns / 1ps

module abe_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  abe_pkg::t_stat i_stat,
    output abe_pkg::t_cmd  o_cmd
);
    import abe_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   in_acc;
    logic   take;

    assign o_in_ready  = (r_state != ST_CALC) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign in_acc      = i_in_valid && o_in_ready;
    assign take        = in_acc && !i_stat.is_nl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LEAD;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        if (in_acc && i_stat.is_nl) begin
            o_cmd.alu_start = 1'b1;
            n_state         = ST_CALC;
        end else begin
            unique case (r_state)
                ST_LEAD: begin
                    if (take && !i_stat.is_ws) begin
                        if (i_stat.is_digit) begin
                            o_cmd.acc_a     = 1'b1;
                            o_cmd.acc_fresh = 1'b1;
                            n_state         = ST_A;
                        end else begin
                            o_cmd.take_op = 1'b1;
                            n_state       = ST_POSTOP;
                        end
                    end
                end
                ST_A: begin
                    if (take) begin
                        if (i_stat.is_digit) begin
                            o_cmd.acc_a = 1'b1;
                        end else if (i_stat.is_ws) begin
                            n_state = ST_PREOP;
                        end else begin
                            o_cmd.take_op = 1'b1;
                            n_state       = ST_POSTOP;
                        end
                    end
                end
                ST_PREOP: begin
                    if (take && !i_stat.is_ws) begin
                        o_cmd.take_op = 1'b1;
                        n_state       = ST_POSTOP;
                    end
                end
                ST_POSTOP: begin
                    if (take && !i_stat.is_ws) begin
                        if (i_stat.is_digit) begin
                            o_cmd.acc_b     = 1'b1;
                            o_cmd.acc_fresh = 1'b1;
                            n_state         = ST_B;
                        end else begin
                            n_state = ST_REST;
                        end
                    end
                end
                ST_B: begin
                    if (take) begin
                        if (i_stat.is_digit) begin
                            o_cmd.acc_b = 1'b1;
                        end else begin
                            n_state = ST_REST;
                        end
                    end
                end
                ST_REST: begin
                    n_state = ST_REST;
                end
                ST_CALC: begin
                    if (i_stat.alu_done) begin
                        o_cmd.finish = 1'b1;
                        n_state      = ST_LEAD;
                    end
                end
                default: begin
                    n_state = ST_LEAD;
                end
            endcase
        end
    end

    // output beat is empty or leaving whenever finish fires
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

endmodule

@@ rtl/abe_alu.sv @@
`timescale 1ns / 1ps

module abe_alu #(
    parameter int VALUE_BITS = abe_pkg::VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [VALUE_BITS-1:0] i_a,
    input  logic [VALUE_BITS-1:0] i_b,
    input  abe_pkg::t_op          i_op,
    input  logic                  i_seen,
    output logic                  o_done,
    output logic [VALUE_BITS-1:0] o_result,
    output abe_pkg::t_status      o_status,
    output abe_pkg::t_op          o_op_used
);
    import abe_pkg::*;

    localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

    logic                  r_busy;
    logic                  r_done;
    t_op                   r_mode;
    logic                  r_neg;
    logic [CNT_BITS-1:0]   r_cnt;
    logic [VALUE_BITS-1:0] r_acc;
    logic [VALUE_BITS-1:0] r_x;
    logic [VALUE_BITS-1:0] r_y;
    logic [VALUE_BITS-1:0] r_result;
    t_status               r_status;
    t_op                   r_op_used;

    logic [VALUE_BITS-1:0] mag_a;
    logic [VALUE_BITS-1:0] mag_b;
    logic [VALUE_BITS-1:0] rem_sh;

    assign mag_a  = i_a[VALUE_BITS-1] ? (~i_a + 1'b1) : i_a;
    assign mag_b  = i_b[VALUE_BITS-1] ? (~i_b + 1'b1) : i_b;
    assign rem_sh = {r_acc[VALUE_BITS-2:0], r_x[VALUE_BITS-1]};

    assign o_done    = r_done;
    assign o_result  = r_result;
    assign o_status  = r_status;
    assign o_op_used = r_op_used;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_mode <= i_op;
                r_neg  <= i_a[VALUE_BITS-1] ^ i_b[VALUE_BITS-1];
                r_acc  <= '0;
                r_cnt  <= CNT_BITS'(VALUE_BITS);
                if (!i_seen) begin
                    r_result  <= '0;
                    r_status  <= STAT_NOOP;
                    r_op_used <= OP_ADD;
                    r_done    <= 1'b1;
                end else begin
                    r_op_used <= i_op;
                    r_status  <= STAT_OK;
                    unique case (i_op)
                        OP_ADD: begin
                            r_result <= i_a + i_b;
                            r_done   <= 1'b1;
                        end
                        OP_SUB: begin
                            r_result <= i_a - i_b;
                            r_done   <= 1'b1;
                        end
                        OP_MUL: begin
                            r_x    <= i_a;
                            r_y    <= i_b;
                            r_busy <= 1'b1;
                        end
                        OP_DIV: begin
                            if (i_b == '0) begin
                                r_result <= '0;
                                r_status <= STAT_DIV0;
                                r_done   <= 1'b1;
                            end else begin
                                r_x    <= mag_a;
                                r_y    <= mag_b;
                                r_busy <= 1'b1;
                            end
                        end
                        default: begin
                            r_done <= 1'b1;
                        end
                    endcase
                end
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    if (r_mode == OP_MUL) begin
                        r_result <= r_acc;
                    end else begin
                        r_result <= r_neg ? (~r_x + 1'b1) : r_x;
                    end
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_mode == OP_MUL) begin
                        // shift-add, low bits of the product are sign-agnostic
                        if (r_y[0]) begin
                            r_acc <= r_acc + r_x;
                        end
                        r_x <= {r_x[VALUE_BITS-2:0], 1'b0};
                        r_y <= {1'b0, r_y[VALUE_BITS-1:1]};
                    end else begin
                        // restoring divide, quotient bits shift into r_x
                        if (rem_sh >= r_y) begin
                            r_acc <= rem_sh - r_y;
                            r_x   <= {r_x[VALUE_BITS-2:0], 1'b1};
                        end else begin
                            r_acc <= rem_sh;
                            r_x   <= {r_x[VALUE_BITS-2:0], 1'b0};
                        end
                    end
                end
            end
        end
    end

endmodule

@@ rtl/abe_dpath.sv @@
`timescale 1ns / 1ps

module abe_dpath #(
    parameter int VALUE_BITS = abe_pkg::VALUE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [abe_pkg::CHAR_BITS-1:0] i_char_code,
    input  abe_pkg::t_cmd                 i_cmd,
    output abe_pkg::t_stat                o_stat,
    output logic signed [abe_pkg::OUT_BITS-1:0] o_value,
    output logic [1:0]                    o_status,
    output logic [1:0]                    o_op_used
);
    import abe_pkg::*;

    logic [VALUE_BITS-1:0] r_first;
    logic [VALUE_BITS-1:0] r_second;
    t_op                   r_op;
    logic                  r_seen;

    logic signed [OUT_BITS-1:0] r_value;
    t_status                    r_status;
    t_op                        r_op_used;

    logic                  is_digit;
    logic                  is_ws;
    logic                  is_op;
    t_op                   op_code;
    logic [VALUE_BITS-1:0] acc_src;
    logic [VALUE_BITS-1:0] acc_next;
    logic [3:0]            digit;

    logic                  alu_done;
    logic [VALUE_BITS-1:0] alu_result;
    t_status               alu_status;
    t_op                   alu_op_used;

    assign is_digit = (i_char_code >= CH_0) && (i_char_code <= CH_9);
    assign is_ws    = (i_char_code == CH_SPACE) || (i_char_code == CH_TAB)
                   || (i_char_code == CH_CR);

    always_comb begin
        is_op   = 1'b1;
        op_code = OP_ADD;
        priority if (i_char_code == CH_PLUS) begin
            op_code = OP_ADD;
        end else if (i_char_code == CH_MINUS) begin
            op_code = OP_SUB;
        end else if (i_char_code == CH_STAR) begin
            op_code = OP_MUL;
        end else if (i_char_code == CH_SLASH) begin
            op_code = OP_DIV;
        end else begin
            is_op = 1'b0;
        end
    end

    assign o_stat.is_digit = is_digit;
    assign o_stat.is_ws    = is_ws;
    assign o_stat.is_nl    = (i_char_code == CH_NL);
    assign o_stat.alu_done = alu_done;

    // acc * 10 + digit as two shifts and adds
    assign digit    = 4'(i_char_code - CH_0);
    assign acc_src  = i_cmd.acc_fresh ? '0 : (i_cmd.acc_a ? r_first : r_second);
    assign acc_next = (acc_src << 3) + (acc_src << 1) + VALUE_BITS'(digit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first  <= '0;
            r_second <= '0;
            r_op     <= OP_ADD;
            r_seen   <= 1'b0;
        end else if (i_cmd.finish) begin
            r_first  <= '0;
            r_second <= '0;
            r_op     <= OP_ADD;
            r_seen   <= 1'b0;
        end else begin
            if (i_cmd.acc_a) begin
                r_first <= acc_next;
            end
            if (i_cmd.acc_b) begin
                r_second <= acc_next;
            end
            if (i_cmd.take_op) begin
                r_seen <= is_op;
                r_op   <= op_code;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_value   <= OUT_BITS'(signed'(alu_result));
            r_status  <= alu_status;
            r_op_used <= alu_op_used;
        end
    end

    assign o_value   = r_value;
    assign o_status  = r_status;
    assign o_op_used = r_op_used;

    abe_alu #(
        .VALUE_BITS (VALUE_BITS)
    ) u_alu (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.alu_start),
        .i_a       (r_first),
        .i_b       (r_second),
        .i_op      (r_op),
        .i_seen    (r_seen),
        .o_done    (alu_done),
        .o_result  (alu_result),
        .o_status  (alu_status),
        .o_op_used (alu_op_used)
    );

endmodule

@@ rtl/ascii_binary_expression_evaluator.sv @@
`timescale 1ns / 1ps
// Characters other than newline are taken one per cycle, no result.
// Newline: +, -, no operator and divide by zero register the ALU result and done flag at
// once, then load the output register; * and / first run VALUE_BITS steps of the
// shift-add / restoring-divide unit. Input ready stays low until the result is loaded,
// and while a loaded result waits on output ready.
// Synchronous active-low reset clears the parser, operands and the output valid.
module ascii_binary_expression_evaluator #(
    parameter int VALUE_BITS = abe_pkg::VALUE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [abe_pkg::CHAR_BITS-1:0] i_char_code,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [abe_pkg::OUT_BITS-1:0] o_value,
    output logic [1:0]                    o_status,
    output logic [1:0]                    o_op_used
);
    import abe_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    abe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    abe_dpath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_char_code (i_char_code),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_value     (o_value),
        .o_status    (o_status),
        .o_op_used   (o_op_used)
    );

endmodule

@@ rtl/abe_checker.sv @@
`timescale 1ns / 1ps

module abe_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic [abe_pkg::CHAR_BITS-1:0] i_char_code,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic signed [abe_pkg::OUT_BITS-1:0] o_value,
    input logic [1:0]                    o_status,
    input logic [1:0]                    o_op_used
);
    import abe_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_value) && $stable(o_status) && $stable(o_op_used))
        else $error("result beat changed while stalled");

    a_noop_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == STAT_NOOP) |-> (o_value == '0) && (o_op_used == OP_ADD))
        else $error("no-operator result not zero/add");

    a_div0_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == STAT_DIV0) |-> (o_value == '0) && (o_op_used == OP_DIV))
        else $error("divide-by-zero result malformed");

    a_busy_before_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared without a compute cycle");

endmodule

bind ascii_binary_expression_evaluator abe_checker u_abe_checker (.*);

@@ tb/sv/ascii_binary_expression_evaluator_tb.sv @@
`timescale 1ns / 1ps

module ascii_binary_expression_evaluator_tb;
    import abe_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int RANDOM_CHARS   = 1200;

    typedef struct {
        logic [31:0] value;
        t_status     status;
        t_op         op;
    } t_answer;

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic [CHAR_BITS-1:0] i_char_code = '0;
    logic                 i_out_ready = 1'b0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic signed [OUT_BITS-1:0] o_value;
    logic [1:0]           o_status;
    logic [1:0]           o_op_used;

    // calculator state mirrored from the block
    t_state      calc_phase;
    logic [31:0] opnd_a;
    logic [31:0] opnd_b;
    t_op         calc_op;
    logic        op_valid;

    t_answer      pending_answers[$];
    logic [7:0]   line_buf[$];
    int           mismatch_count = 0;
    int           chars_sent     = 0;
    int           idle_cycles    = 0;
    int           hold_request   = 0;
    bit           send_idle_on   = 1'b1;
    bit           recv_idle_on   = 1'b1;

    ascii_binary_expression_evaluator DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_char_code (i_char_code),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_value     (o_value),
        .o_status    (o_status),
        .o_op_used   (o_op_used)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_CR;
    endfunction

    function automatic bit is_numeral(logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic logic [31:0] shift_in(logic [31:0] acc, logic [7:0] c);
        return acc * 32'd10 + {24'd0, c} - {24'd0, CH_0};
    endfunction

    // truncate toward zero; most negative / -1 wraps to itself
    function automatic logic [31:0] trunc_div(logic [31:0] a, logic [31:0] b);
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] q;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q  = ma / mb;
        return (a[31] ^ b[31]) ? -q : q;
    endfunction

    function automatic void clear_calc();
        calc_phase = ST_LEAD;
        opnd_a     = '0;
        opnd_b     = '0;
        calc_op    = OP_ADD;
        op_valid   = 1'b0;
    endfunction

    function automatic void fill_op_slot(logic [7:0] c);
        op_valid = 1'b1;
        case (c)
            CH_PLUS:  calc_op = OP_ADD;
            CH_MINUS: calc_op = OP_SUB;
            CH_STAR:  calc_op = OP_MUL;
            CH_SLASH: calc_op = OP_DIV;
            default: begin
                op_valid = 1'b0;
                calc_op  = OP_ADD;
            end
        endcase
        calc_phase = ST_POSTOP;
    endfunction

    // advance the calculator by one character; queue the answer on newline
    function automatic void parse_char(logic [7:0] c);
        t_answer ans;
        if (c == CH_NL) begin
            ans.value  = '0;
            ans.status = STAT_OK;
            ans.op     = calc_op;
            if (!op_valid) begin
                ans.status = STAT_NOOP;
                ans.op     = OP_ADD;
            end else begin
                case (calc_op)
                    OP_ADD: ans.value = opnd_a + opnd_b;
                    OP_SUB: ans.value = opnd_a - opnd_b;
                    OP_MUL: ans.value = opnd_a * opnd_b;
                    default: begin
                        if (opnd_b == '0) ans.status = STAT_DIV0;
                        else ans.value = trunc_div(opnd_a, opnd_b);
                    end
                endcase
            end
            pending_answers.push_back(ans);
            clear_calc();
            return;
        end
        case (calc_phase)
            ST_LEAD: begin
                if (is_numeral(c)) begin
                    opnd_a     = shift_in('0, c);
                    calc_phase = ST_A;
                end else if (!is_blank(c)) begin
                    fill_op_slot(c);
                end
            end
            ST_A: begin
                if (is_numeral(c)) opnd_a = shift_in(opnd_a, c);
                else if (is_blank(c)) calc_phase = ST_PREOP;
                else fill_op_slot(c);
            end
            ST_PREOP: begin
                if (!is_blank(c)) fill_op_slot(c);
            end
            ST_POSTOP: begin
                if (is_numeral(c)) begin
                    opnd_b     = shift_in('0, c);
                    calc_phase = ST_B;
                end else if (!is_blank(c)) begin
                    calc_phase = ST_REST;
                end
            end
            ST_B: begin
                if (is_numeral(c)) opnd_b = shift_in(opnd_b, c);
                else calc_phase = ST_REST;
            end
            default: calc_phase = ST_REST;
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got 0x%08h, expected 0x%08h", what, got, want);
        mismatch_count++;
    endtask

    // hold valid across back-to-back beats; drop it only for a gap
    task automatic send_char(logic [7:0] c);
        int gap;
        gap = send_idle_on ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_char_code <= c;
        do @(posedge i_clk); while (!o_in_ready);
        parse_char(c);
        chars_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
    endtask

    task automatic send_line();
        foreach (line_buf[i]) send_char(line_buf[i]);
        line_buf.delete();
    endtask

    task automatic push_blanks(int max_n);
        int pick;
        repeat ($urandom_range(0, max_n)) begin
            pick = $urandom_range(0, 2);
            line_buf.push_back(pick == 0 ? CH_SPACE : (pick == 1 ? CH_TAB : CH_CR));
        end
    endtask

    task automatic push_digits();
        int pick;
        int n;
        pick = $urandom_range(0, 19);
        n = (pick == 0) ? 0 : (pick < 15 ? $urandom_range(1, 4) : $urandom_range(5, 12));
        repeat (n) line_buf.push_back(CH_0 + 8'($urandom_range(0, 9)));
    endtask

    task automatic push_junk(int max_n);
        logic [7:0] b;
        repeat ($urandom_range(1, max_n)) begin
            b = 8'($urandom_range(0, 255));
            if (b == CH_NL) b = b + 8'd1;
            line_buf.push_back(b);
        end
    endtask

    task automatic build_expression();
        int pick;
        push_blanks(2);
        push_digits();
        push_blanks(2);
        pick = $urandom_range(0, 3);
        case (pick)
            0: line_buf.push_back(CH_PLUS);
            1: line_buf.push_back(CH_MINUS);
            2: line_buf.push_back(CH_STAR);
            default: line_buf.push_back(CH_SLASH);
        endcase
        push_blanks(2);
        if ($urandom_range(0, 9) == 0) line_buf.push_back(CH_0);
        else push_digits();
        if ($urandom_range(0, 3) == 0) push_junk(4);
    endtask

    task automatic test_operators();
        send_text("12+34\n");
        send_text(" \t7 *\r 6\n");
        send_text("100-250\n");
        send_text("-99/7\n");
        send_text("2147483648/7\n");
    endtask

    task automatic test_special_cases();
        send_text("\n");
        send_text("42\n");
        send_text("12x5\n");
        send_text("5/0\n");
        send_text("9/\n");
        send_text("2147483648/4294967295\n");
        send_text("99999999999*3\n");
        send_text("4294967295+1\n");
        // NUL in the operator slot, then high bytes after the second operand
        line_buf = '{CH_0 + 8'd7, 8'h00, CH_0 + 8'd5, CH_NL};
        send_line();
        line_buf = '{CH_0 + 8'd3, CH_PLUS, CH_0 + 8'd4, 8'hFF, 8'h80, CH_0 + 8'd9, CH_NL};
        send_line();
    endtask

    task automatic test_random_lines();
        int kind;
        int keep;
        int lines = 0;
        while (chars_sent < RANDOM_CHARS) begin
            if (lines % 20 == 0) begin
                send_idle_on = $urandom_range(0, 3) != 0;
                recv_idle_on = $urandom_range(0, 3) != 0;
            end
            kind = $urandom_range(0, 15);
            if (kind < 13) begin
                build_expression();
                // cut a few lines short before the newline
                if (kind >= 11) begin
                    keep = $urandom_range(0, line_buf.size());
                    while (line_buf.size() > keep) void'(line_buf.pop_back());
                end
            end else if ($urandom_range(0, 1) == 1) begin
                push_junk(10);
            end
            line_buf.push_back(CH_NL);
            send_line();
            lines++;
        end
    endtask

    task automatic test_output_backpressure();
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        hold_request = 150;
        repeat (12) begin
            build_expression();
            line_buf.push_back(CH_NL);
            send_line();
        end
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
    endtask

    initial begin : result_monitor
        int      stall;
        t_answer want;
        forever begin
            stall = recv_idle_on ? $urandom_range(0, 8) : 0;
            if (hold_request > 0) begin
                stall        = hold_request;
                hold_request = 0;
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_rst_n));
            if (pending_answers.size() == 0) begin
                report_mismatch("result with nothing pending", o_value, '0);
            end else begin
                want = pending_answers.pop_front();
                if (o_value !== want.value)
                    report_mismatch("value", o_value, want.value);
                if (o_status !== want.status)
                    report_mismatch("status", 32'(o_status), 32'(want.status));
                if (o_op_used !== want.op)
                    report_mismatch("op_used", 32'(o_op_used), 32'(want.op));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        clear_calc();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_operators();
        test_special_cases();
        test_random_lines();
        test_output_backpressure();
        i_in_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ ascii_binary_expression_evaluator.f @@
rtl/abe_pkg.sv
rtl/abe_ctrl.sv
rtl/abe_alu.sv
rtl/abe_dpath.sv
rtl/ascii_binary_expression_evaluator.sv
rtl/abe_checker.sv
tb/sv/ascii_binary_expression_evaluator_tb.sv
